/* rtl/srcd_pkg.sv */
// Shared types, constants and helper functions for the settings record
// check and decode block. No dependencies.
package srcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned OUT_TDATA_W = 80;

  // Byte positions inside the 24-byte record
  localparam logic [POS_W-1:0] POS_MAGIC0  = 5'd0;
  localparam logic [POS_W-1:0] POS_MAGIC1  = 5'd1;
  localparam logic [POS_W-1:0] POS_MAGIC2  = 5'd2;
  localparam logic [POS_W-1:0] POS_MAGIC3  = 5'd3;
  localparam logic [POS_W-1:0] POS_VERSION = 5'd4;
  localparam logic [POS_W-1:0] POS_SIZE    = 5'd5;
  localparam logic [POS_W-1:0] POS_SEQ0    = 5'd6;
  localparam logic [POS_W-1:0] POS_SEQ1    = 5'd7;
  localparam logic [POS_W-1:0] POS_SEQ2    = 5'd8;
  localparam logic [POS_W-1:0] POS_SEQ3    = 5'd9;
  localparam logic [POS_W-1:0] POS_FLAGS   = 5'd10;
  localparam logic [POS_W-1:0] POS_YEAR    = 5'd11;
  localparam logic [POS_W-1:0] POS_MONTH   = 5'd12;
  localparam logic [POS_W-1:0] POS_DAY     = 5'd13;
  localparam logic [POS_W-1:0] POS_STEPS0  = 5'd14;
  localparam logic [POS_W-1:0] POS_STEPS1  = 5'd15;
  localparam logic [POS_W-1:0] POS_CRC_END = 5'd21;
  localparam logic [POS_W-1:0] POS_CRC_LO  = 5'd21;
  localparam logic [POS_W-1:0] POS_CRC_HI  = 5'd22;
  localparam logic [POS_W-1:0] POS_COMMIT  = 5'd23;

  localparam logic [BYTE_W-1:0] MAGIC_B0    = 8'h55;
  localparam logic [BYTE_W-1:0] MAGIC_B1    = 8'h53;
  localparam logic [BYTE_W-1:0] MAGIC_B2    = 8'h52;
  localparam logic [BYTE_W-1:0] MAGIC_B3    = 8'h31;
  localparam logic [BYTE_W-1:0] REC_VERSION = 8'h01;
  localparam logic [BYTE_W-1:0] REC_LEN     = 8'd24;
  localparam logic [BYTE_W-1:0] COMMIT_BYTE = 8'hA5;
  localparam logic [BYTE_W-1:0] FLAG_KNOWN  = 8'h03;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam logic [BYTE_W-1:0] MONTH_FEB = 8'd2;
  localparam logic [BYTE_W-1:0] MONTH_DEC = 8'd12;

  // One record word presented to the decode core
  typedef struct packed {
    logic              en;
    logic              start;
    logic [BYTE_W-1:0] data;
  } srcd_step_t;

  typedef struct packed {
    logic        ok;
    logic        wrist_wake;
    logic        app_sync;
    logic [7:0]  year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [15:0] steps;
    logic [31:0] sequence_no;
  } srcd_result_t;

  function automatic logic [BYTE_W-1:0] month_len(input logic [BYTE_W-1:0] m);
    logic [BYTE_W-1:0] len;
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 8'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    len = 8'd30;
      8'd2:                                       len = 8'd28;
      default:                                    len = 8'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [BYTE_W-1:0] y,
                                   input logic [BYTE_W-1:0] m,
                                   input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] maxd;
    maxd = month_len(m);
    if (m == MONTH_FEB && y[1:0] == 2'b00) begin
      maxd = 8'd29;
    end
    return (m != '0) && (m <= MONTH_DEC) && (d != '0) && (d <= maxd);
  endfunction

endpackage

/* rtl/srcd_crc16.sv */
// Byte-wide CRC16-CCITT update, MSB first, polynomial from srcd_pkg.
// Depends on srcd_pkg.
module srcd_crc16
  import srcd_pkg::*;
(
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [BYTE_W-1:0] data_in,
  output logic [CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

/* rtl/srcd_rec_core.sv */
// Record state: byte position, running CRC, captured fields and final checks.
// Depends on srcd_pkg and srcd_crc16.
module srcd_rec_core
  import srcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  srcd_step_t   step,
  output logic         res_valid,
  output srcd_result_t res
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic              hdr_r, hdr_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic [7:0]        year_r, year_nxt;
  logic [7:0]        month_r, month_nxt;
  logic [7:0]        day_r, day_nxt;
  logic [15:0]       steps_r, steps_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [CRC_W-1:0]  scrc_r, scrc_nxt;

  logic [POS_W-1:0]  pos;
  logic [CRC_W-1:0]  crc_base, crc_upd;
  logic              hdr_base;
  logic              ok;

  assign pos      = step.start ? POS_MAGIC0 : pos_r;
  assign crc_base = (pos == POS_MAGIC0) ? CRC_INIT : crc_r;
  assign hdr_base = (pos == POS_MAGIC0) ? 1'b1 : hdr_r;

  srcd_crc16 u_crc (
    .crc_in  (crc_base),
    .data_in (step.data),
    .crc_out (crc_upd)
  );

  always_comb begin
    crc_nxt   = (pos < POS_CRC_END) ? crc_upd : crc_base;
    hdr_nxt   = hdr_base;
    flags_nxt = flags_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    steps_nxt = steps_r;
    seq_nxt   = seq_r;
    scrc_nxt  = scrc_r;
    pos_nxt   = (pos == POS_COMMIT) ? POS_MAGIC0 : pos + 5'd1;
    case (pos)
      POS_MAGIC0:  hdr_nxt = hdr_base & (step.data == MAGIC_B0);
      POS_MAGIC1:  hdr_nxt = hdr_base & (step.data == MAGIC_B1);
      POS_MAGIC2:  hdr_nxt = hdr_base & (step.data == MAGIC_B2);
      POS_MAGIC3:  hdr_nxt = hdr_base & (step.data == MAGIC_B3);
      POS_VERSION: hdr_nxt = hdr_base & (step.data == REC_VERSION);
      POS_SIZE:    hdr_nxt = hdr_base & (step.data == REC_LEN);
      POS_SEQ0:    seq_nxt = {24'd0, step.data};
      POS_SEQ1:    seq_nxt = seq_r | {16'd0, step.data, 8'd0};
      POS_SEQ2:    seq_nxt = seq_r | {8'd0, step.data, 16'd0};
      POS_SEQ3:    seq_nxt = seq_r | {step.data, 24'd0};
      POS_FLAGS:   flags_nxt = step.data;
      POS_YEAR:    year_nxt = step.data;
      POS_MONTH:   month_nxt = step.data;
      POS_DAY:     day_nxt = step.data;
      POS_STEPS0:  steps_nxt = {8'd0, step.data};
      POS_STEPS1:  steps_nxt = steps_r | {step.data, 8'd0};
      POS_CRC_LO:  scrc_nxt = {8'd0, step.data};
      POS_CRC_HI:  scrc_nxt = scrc_r | {step.data, 8'd0};
      default:     ;
    endcase
  end

  // Final checks on the commit byte; fields are already captured
  assign res_valid = (pos == POS_COMMIT);
  assign ok = hdr_base && (step.data == COMMIT_BYTE) && (scrc_r == crc_base) &&
              ((flags_r & ~FLAG_KNOWN) == '0) && date_ok(year_r, month_r, day_r);

  always_comb begin
    res = '0;
    if (ok) begin
      res.ok          = 1'b1;
      res.wrist_wake  = flags_r[0];
      res.app_sync    = flags_r[1];
      res.year        = year_r;
      res.month       = month_r;
      res.day         = day_r;
      res.steps       = steps_r;
      res.sequence_no = seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_MAGIC0;
      crc_r   <= CRC_INIT;
      hdr_r   <= 1'b1;
      flags_r <= '0;
      year_r  <= '0;
      month_r <= '0;
      day_r   <= '0;
      steps_r <= '0;
      seq_r   <= '0;
      scrc_r  <= '0;
    end else if (step.en) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      hdr_r   <= hdr_nxt;
      flags_r <= flags_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      steps_r <= steps_nxt;
      seq_r   <= seq_nxt;
      scrc_r  <= scrc_nxt;
    end
  end

endmodule

/* rtl/settings_record_check_decode_top.sv */
// Settings record check and decode, top level: input word register, record
// core and result register. Depends on srcd_pkg and srcd_rec_core.
// Byte 23 is held in the input register, and the core's byte-wide CRC update and checks
// place the result word in the result register, which drives out_tvalid.
// Throughput: one record byte per cycle while no result waits in a blocked result
// register. Reset (rst_n, synchronous, active low): position 0, CRC 0xFFFF, both registers empty.
module settings_record_check_decode_top
  import srcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] rec_byte
  input  logic                   in_tuser,   // [0] record_start
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] record_ok, [1] wrist_wake, [2] app_sync, [10:3] rec_year,
  // [18:11] rec_month, [26:19] rec_day, [42:27] step_count,
  // [74:43] record_sequence, [79:75] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Input word register
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_start_r;

  // Result register
  logic              out_valid_r;
  srcd_result_t      out_res_r;

  srcd_step_t        step;
  logic              core_res_valid;
  srcd_result_t      core_res;
  logic              out_free;
  logic              step_en;

  // The result slot frees up when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;
  // Advance the held word unless it produces a result that has nowhere to go
  assign step_en  = in_valid_r && (!core_res_valid || out_free);
  assign in_tready = !in_valid_r || step_en;

  assign step.en    = step_en;
  assign step.start = in_start_r;
  assign step.data  = in_byte_r;

  srcd_rec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  // Hold the accepted word until the core consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  // Load a result on the commit byte, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && core_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0,
                       out_res_r.sequence_no,
                       out_res_r.steps,
                       out_res_r.day,
                       out_res_r.month,
                       out_res_r.year,
                       out_res_r.app_sync,
                       out_res_r.wrist_wake,
                       out_res_r.ok};

  // A held word only stalls behind a full, blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !step_en) |-> (core_res_valid && out_valid_r && !out_tready))
    else $error("input word stalled without a blocked result");

  // A result computed this cycle is presented next cycle
  a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && core_res_valid) |=> out_valid_r)
    else $error("result lost on the way to the output register");

  // A rejected record carries all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.ok) |-> (out_tdata[79:1] == '0))
    else $error("rejected record with nonzero fields");

  // An accepted record always has a real month and day
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.ok) |->
      (out_res_r.month != '0 && out_res_r.month <= MONTH_DEC && out_res_r.day != '0))
    else $error("accepted record with invalid date");

endmodule
